// ===== rtl/core/pdjs_pkg.sv =====
// shared types and constants of the periodic deadline job scheduler
`default_nettype none

package pdjs_pkg;

  // field widths
  localparam int JOB_W   = 8;
  localparam int IVL_W   = 24;
  localparam int REM_W   = 32;
  localparam int STAMP_W = 16;
  localparam int WAIT_W  = 31;
  localparam int AMT_W   = 33;
  localparam int DIFF_W  = 34;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_SELECT   = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_REMOVE   = 3'd3,
    CMD_UPDATE   = 3'd4,
    CMD_STOP     = 3'd5
  } cmd_t;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdjs_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module pdjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/periodic_deadline_job_scheduler_top.sv =====
// top level of the periodic deadline job scheduler
//
// Usage: one request on the input channel (cmd, job_id, interval, run_ms)
// gives exactly one result on the output channel (selected_job, wait_time,
// status). Both channels use valid/ready; a request is taken when in_valid
// and in_ready are high at a clock edge, a result when out_valid and
// out_ready are.
// Add, select and complete walk the job table one slot per cycle through
// the shared subtract/compare unit and the table rams before their result
// is loaded. Remove, update, stop, unknown codes and every request after a
// stop skip the walk and go from idle straight to the finish state, which
// loads their result. One request is in work at a time and the sequencer
// returns to idle before it takes the next, so the block cannot take a new
// request before it is through with the last one.
// The result sits in an output register: a new request is taken while it
// waits, and the block holds its finished result until out_ready if the
// previous one has not yet been taken.
// Reset (rst, synchronous, active high) empties the table, clears the
// current job, the last wait, the add stamp and the stopped flag.
`default_nettype none

module periodic_deadline_job_scheduler_top #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   cmd,
  input  wire logic [pdjs_pkg::JOB_W-1:0]   job_id,
  input  wire logic [pdjs_pkg::IVL_W-1:0]   interval,
  input  wire logic [pdjs_pkg::IVL_W-1:0]   run_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [pdjs_pkg::JOB_W-1:0]   selected_job,
  output logic      [pdjs_pkg::WAIT_W-1:0]  wait_time,
  output logic      [1:0]                   status
);

  import pdjs_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);

  // sequencer
  state_t state, state_next;
  logic   walk_issue;
  logic   fin_go;
  logic   accept;

  // control state
  logic [MAX_JOBS-1:0] entry_valid;
  logic [STAMP_W-1:0]  stamp_counter;
  logic [IW-1:0]       current_slot;
  logic                current_live;
  logic [REM_W-1:0]    last_wait;
  logic                halted;
  logic [CW-1:0]       rd_cnt;
  logic                p_act;
  logic [IW-1:0]       p_idx;
  logic                found;

  // latched request and walk results
  logic [2:0]         cmd_r;
  logic [JOB_W-1:0]   job_r;
  logic [IVL_W-1:0]   ivl_r;
  logic [AMT_W-1:0]   amount;
  logic [IW-1:0]      best_idx;
  logic [REM_W-1:0]   best_rem;
  logic [STAMP_W-1:0] best_age;
  logic [JOB_W-1:0]   best_job;

  // ram ports
  logic [IW-1:0]      raddr;
  logic [JOB_W-1:0]   job_rd;
  logic [IVL_W-1:0]   per_rd;
  logic [REM_W-1:0]   rem_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic               job_we, per_we, rem_we, stamp_we;
  logic [IW-1:0]      per_waddr, rem_waddr;
  logic [IVL_W-1:0]   per_wdata;
  logic [REM_W-1:0]   rem_wdata;

  // shared subtract unit and walk decisions
  logic [DIFF_W-1:0]  sub_a, sub_b, diff;
  logic               rem_lt, rem_eq;
  logic [REM_W-1:0]   charged;
  logic [STAMP_W-1:0] age;
  logic               sel_take, add_take, cmp_take;

  // finish results
  logic [1:0]         fin_status;
  logic [JOB_W-1:0]   fin_job;
  logic [REM_W-1:0]   fin_wait;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (halted || !(cmd == CMD_ADD || cmd == CMD_SELECT || cmd == CMD_COMPLETE)) begin
            state_next = S_FIN;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_cnt == CW'(MAX_JOBS) && !p_act) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    walk_issue = 1'b0;
    fin_go     = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_WALK: walk_issue = (rd_cnt < CW'(MAX_JOBS));
      S_FIN:  fin_go = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // shared subtractor: charge for complete, ordering compare for select
  always_comb begin
    sub_a = {{(DIFF_W-REM_W){rem_rd[REM_W-1]}}, rem_rd};
    if (cmd_r == CMD_COMPLETE) begin
      sub_b = {1'b0, amount};
    end else begin
      sub_b = {{(DIFF_W-REM_W){best_rem[REM_W-1]}}, best_rem};
    end
    diff   = sub_a - sub_b;
    rem_lt = diff[DIFF_W-1];
    rem_eq = (rem_rd == best_rem);
    // saturate at the low bound of a signed 32-bit value
    if (diff[DIFF_W-1] && (diff[DIFF_W-2:REM_W-1] != 2'b11)) begin
      charged = {1'b1, {(REM_W-1){1'b0}}};
    end else begin
      charged = diff[REM_W-1:0];
    end
  end

  // per-slot decisions of the walk
  assign age      = stamp_counter - stamp_rd;
  assign cmp_take = !found || rem_lt || (rem_eq && (age < best_age));
  assign sel_take = p_act && (cmd_r == CMD_SELECT) && entry_valid[p_idx] && cmp_take;
  assign add_take = p_act && (cmd_r == CMD_ADD) && !found && !entry_valid[p_idx];

  // ram control
  always_comb begin
    raddr     = rd_cnt[IW-1:0];
    job_we    = 1'b0;
    stamp_we  = 1'b0;
    per_we    = 1'b0;
    per_waddr = best_idx;
    per_wdata = ivl_r;
    rem_we    = 1'b0;
    rem_waddr = best_idx;
    rem_wdata = {{(REM_W-IVL_W){1'b0}}, ivl_r};
    if (state == S_WALK) begin
      // charge elapsed time, reload the current slot
      if (p_act && (cmd_r == CMD_COMPLETE) && entry_valid[p_idx]) begin
        rem_we    = 1'b1;
        rem_waddr = p_idx;
        if (current_live && (p_idx == current_slot)) begin
          rem_wdata = {{(REM_W-IVL_W){1'b0}}, per_rd};
        end else begin
          rem_wdata = charged;
        end
      end
    end else if (fin_go && !halted) begin
      if (cmd_r == CMD_ADD && found) begin
        job_we   = 1'b1;
        stamp_we = 1'b1;
        per_we   = 1'b1;
        rem_we   = 1'b1;
      end else if (cmd_r == CMD_UPDATE && current_live) begin
        per_we    = 1'b1;
        per_waddr = current_slot;
      end
    end
  end

  // result of the finished request
  always_comb begin
    fin_status = ST_OK;
    fin_job    = '0;
    fin_wait   = '0;
    if (halted) begin
      fin_status = ST_STOPPED;
    end else begin
      unique case (cmd_r)
        CMD_ADD: fin_status = found ? ST_OK : ST_FULL;
        CMD_SELECT: begin
          if (found) begin
            fin_job  = best_job;
            fin_wait = best_rem[REM_W-1] ? '0 : best_rem;
          end else begin
            fin_status = ST_EMPTY;
          end
        end
        CMD_COMPLETE, CMD_REMOVE, CMD_UPDATE: begin
          fin_status = current_live ? ST_OK : ST_EMPTY;
        end
        CMD_STOP: fin_status = ST_STOPPED;
        default:  fin_status = ST_OK;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_valid   <= '0;
      stamp_counter <= '0;
      current_slot  <= '0;
      current_live  <= 1'b0;
      last_wait     <= '0;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
      rd_cnt        <= '0;
      p_act         <= 1'b0;
      found         <= 1'b0;
    end else begin
      state <= state_next;
      // output handshake
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // start of a request
      if (accept) begin
        rd_cnt <= '0;
        p_act  <= 1'b0;
        found  <= 1'b0;
      end
      // table walk
      if (state == S_WALK) begin
        p_act <= walk_issue;
        if (walk_issue) begin
          rd_cnt <= rd_cnt + CW'(1);
        end
        if (sel_take || add_take) begin
          found <= 1'b1;
        end
      end
      // command effects
      if (fin_go && !halted) begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (found) begin
              entry_valid[best_idx] <= 1'b1;
              stamp_counter         <= stamp_counter + STAMP_W'(1);
            end
          end
          CMD_SELECT: begin
            current_live <= found;
            if (found) begin
              current_slot <= best_idx;
              last_wait    <= fin_wait;
            end
          end
          CMD_REMOVE: begin
            if (current_live) begin
              entry_valid[current_slot] <= 1'b0;
              current_live              <= 1'b0;
            end
          end
          CMD_STOP: halted <= 1'b1;
          default: halted <= halted;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      job_r  <= job_id;
      ivl_r  <= interval;
      amount <= {1'b0, last_wait} + {{(AMT_W-IVL_W){1'b0}}, run_ms};
    end
    if (state == S_WALK) begin
      p_idx <= rd_cnt[IW-1:0];
    end
    if (sel_take || add_take) begin
      best_idx <= p_idx;
    end
    if (sel_take) begin
      best_rem <= rem_rd;
      best_age <= age;
      best_job <= job_rd;
    end
    if (fin_go) begin
      selected_job <= fin_job;
      wait_time    <= fin_wait[WAIT_W-1:0];
      status       <= fin_status;
    end
  end

  // table storage
  pdjs_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (best_idx),
    .wdata (job_r),
    .raddr (raddr),
    .rdata (job_rd)
  );

  pdjs_ram #(.WIDTH(IVL_W), .DEPTH(MAX_JOBS)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (raddr),
    .rdata (per_rd)
  );

  pdjs_ram #(.WIDTH(REM_W), .DEPTH(MAX_JOBS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (raddr),
    .rdata (rem_rd)
  );

  pdjs_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_JOBS)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (best_idx),
    .wdata (stamp_counter),
    .raddr (raddr),
    .rdata (stamp_rd)
  );

`ifndef NO_ASSERTIONS
  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // the current job always points at an occupied slot
  a_current_valid: assert property (@(posedge clk) disable iff (rst)
    current_live |-> entry_valid[current_slot])
    else $error("current job refers to a free slot");

  // once stopped, only reset restarts the block
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("stopped flag cleared without reset");

  // the add stamp moves only on a successful add
  a_stamp_add: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (stamp_counter != $past(stamp_counter)))
      |-> $past(fin_go && !halted && found && (cmd_r == CMD_ADD)))
    else $error("add stamp moved outside an add");

  // walk counter never passes the table size
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CW'(MAX_JOBS))
    else $error("walk counter beyond table");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_periodic_deadline_job_scheduler_top.sv =====
// self-checking bench for the periodic deadline job scheduler: directed table, random command mix
`timescale 1ns / 100ps

module tb_periodic_deadline_job_scheduler_top;
  import pdjs_pkg::*;

  localparam int MAX_JOBS = 16;
  // codes the block does not define, which report ok and change nothing
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam logic [23:0] IVL_MAX = 24'hFF_FFFF;
  localparam longint REM_FLOOR = -64'sd2147483648;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [WAIT_W-1:0] wait_ms;
    logic [1:0]        st;
  } sched_result_t;

  typedef struct {
    logic [2:0]       op;
    logic [JOB_W-1:0] id;
    logic [IVL_W-1:0] ivl;
    logic [IVL_W-1:0] rt;
    bit               typed;
    logic [1:0]       st;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [2:0]       cmd = '0;
  logic [JOB_W-1:0] job_id = '0;
  logic [IVL_W-1:0] interval = '0;
  logic [IVL_W-1:0] run_ms = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [JOB_W-1:0]  selected_job;
  logic [WAIT_W-1:0] wait_time;
  logic [1:0]        status;

  // predicted scheduler state
  bit                 slot_used [MAX_JOBS] = '{default: 1'b0};
  logic [JOB_W-1:0]   slot_job [MAX_JOBS];
  logic [IVL_W-1:0]   slot_period [MAX_JOBS];
  logic signed [31:0] slot_left [MAX_JOBS];
  logic [15:0]        slot_stamp [MAX_JOBS];
  logic [15:0]        add_stamp = '0;
  int                 cur_slot = 0;
  bit                 cur_live = 1'b0;
  logic [31:0]        prev_wait = '0;
  bit                 stopped = 1'b0;

  sched_result_t pending_results[$];
  stim_row_t     head_rows[$];
  stim_row_t     stop_rows[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int checked = 0;
  int err_count = 0;
  int sat_events = 0;
  int st_seen [4] = '{default: 0};

  periodic_deadline_job_scheduler_top #(
    .MAX_JOBS(MAX_JOBS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .job_id(job_id),
    .interval(interval),
    .run_ms(run_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .selected_job(selected_job),
    .wait_time(wait_time),
    .status(status)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result consumer with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < MAX_JOBS; i++) n += slot_used[i];
    return n;
  endfunction

  // next result of the scheduler for one request, updating the predicted state
  function automatic sched_result_t predict_schedule(input logic [2:0] op,
                                                     input logic [JOB_W-1:0] id,
                                                     input logic [IVL_W-1:0] ivl,
                                                     input logic [IVL_W-1:0] rt);
    sched_result_t r;
    int            best;
    bit            found;
    logic [15:0]   age;
    logic [15:0]   best_age;
    longint        amount;
    longint        v;
    r = '0;
    if (stopped) begin
      r.st = ST_STOPPED;
      return r;
    end
    case (op)
      CMD_ADD: begin
        // lowest free slot, remaining starts at the period
        r.st = ST_FULL;
        for (int i = 0; i < MAX_JOBS; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_job[i] = id;
            slot_period[i] = ivl;
            slot_left[i] = signed'({8'd0, ivl});
            slot_stamp[i] = add_stamp;
            add_stamp = add_stamp + 16'd1;
            r.st = ST_OK;
            break;
          end
        end
      end
      CMD_SELECT: begin
        // least remaining, newest add wins a tie
        found = 1'b0;
        best = 0;
        best_age = '0;
        for (int i = 0; i < MAX_JOBS; i++) begin
          if (slot_used[i]) begin
            age = add_stamp - slot_stamp[i];
            if (!found || slot_left[i] < slot_left[best] ||
                (slot_left[i] == slot_left[best] && age < best_age)) begin
              best = i;
              best_age = age;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          cur_live = 1'b0;
          r.st = ST_EMPTY;
        end else begin
          cur_slot = best;
          cur_live = 1'b1;
          prev_wait = (slot_left[best] < 0) ? 32'd0 : slot_left[best];
          r.job = slot_job[best];
          r.wait_ms = prev_wait[WAIT_W-1:0];
        end
      end
      CMD_COMPLETE: begin
        // charge sleep plus run time everywhere, then reload the current job
        amount = longint'(prev_wait) + longint'(rt);
        for (int i = 0; i < MAX_JOBS; i++) begin
          if (slot_used[i]) begin
            v = longint'(slot_left[i]) - amount;
            if (v < REM_FLOOR) begin
              v = REM_FLOOR;
              sat_events++;
            end
            slot_left[i] = v[31:0];
          end
        end
        if (!cur_live) begin
          r.st = ST_EMPTY;
        end else begin
          slot_left[cur_slot] = signed'({8'd0, slot_period[cur_slot]});
        end
      end
      CMD_REMOVE: begin
        if (!cur_live) begin
          r.st = ST_EMPTY;
        end else begin
          slot_used[cur_slot] = 1'b0;
          cur_live = 1'b0;
        end
      end
      CMD_UPDATE: begin
        if (!cur_live) begin
          r.st = ST_EMPTY;
        end else begin
          slot_period[cur_slot] = ivl;
        end
      end
      CMD_STOP: begin
        stopped = 1'b1;
        r.st = ST_STOPPED;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // present one request, wait for it to be taken, queue what it should give
  task automatic send_request(input logic [2:0] op, input logic [JOB_W-1:0] id,
                              input logic [IVL_W-1:0] ivl, input logic [IVL_W-1:0] rt,
                              input bit typed, input logic [1:0] st);
    sched_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    job_id <= id;
    interval <= ivl;
    run_ms <= rt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_schedule(op, id, ivl, rt);
    if (typed) begin
      r = '0;
      r.st = st;
    end
    pending_results.push_back(r);
    sent++;
  endtask

  function automatic logic [IVL_W-1:0] rand_interval();
    case ($urandom_range(5))
      0: return '0;
      1: return IVL_MAX;
      2: return IVL_W'($urandom_range(1, 8));
      3: return IVL_W'($urandom_range(0, 1000));
      default: return IVL_W'($urandom);
    endcase
  endfunction

  function automatic logic [IVL_W-1:0] rand_runtime();
    case ($urandom_range(4))
      0: return '0;
      1: return IVL_MAX;
      2: return IVL_W'($urandom_range(0, 500));
      default: return IVL_W'($urandom);
    endcase
  endfunction

  // random request of one kind, every field randomized
  task automatic request_rand(input logic [2:0] op);
    send_request(op, JOB_W'($urandom), rand_interval(), rand_runtime(), 1'b0, ST_OK);
  endtask

  // one random command sequence, mostly well-formed scheduling rounds
  task automatic run_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      request_rand(CMD_SELECT);
      if ($urandom_range(3) == 0) request_rand(CMD_UPDATE);
      if ($urandom_range(5) == 0) request_rand(CMD_REMOVE);
      else request_rand(CMD_COMPLETE);
    end else if (kind < 60) begin
      n = $urandom_range(1, 3);
      repeat (n) request_rand(CMD_ADD);
    end else if (kind < 68) begin
      // fill up and push one past full
      n = MAX_JOBS + 1 - used_count();
      repeat (n) request_rand(CMD_ADD);
    end else if (kind < 76) begin
      // empty the table through select and remove, then select on empty
      n = used_count();
      repeat (n) begin
        request_rand(CMD_SELECT);
        request_rand(CMD_REMOVE);
      end
      request_rand(CMD_SELECT);
    end else if (kind < 84) begin
      request_rand(CMD_COMPLETE);
    end else if (kind < 90) begin
      n = $urandom_range(5, 20);
      repeat (n) request_rand(CMD_COMPLETE);
    end else if (kind < 96) begin
      request_rand($urandom_range(1) ? CMD_REMOVE : CMD_UPDATE);
    end else begin
      request_rand($urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, e, a);
    end
  endtask

  // scoreboard: each result against the oldest prediction
  always @(posedge clk) begin : result_check
    sched_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, got job %0d wait %0d status %0d",
                 $time, selected_job, wait_time, status);
      end else begin
        e = pending_results.pop_front();
        check_field("selected_job", e.job, selected_job);
        check_field("wait_time", e.wait_ms, wait_time);
        check_field("status", e.st, status);
        checked++;
        if (!$isunknown(status)) st_seen[status]++;
      end
    end
  end

  function automatic stim_row_t dir_row(input logic [2:0] op, input logic [JOB_W-1:0] id,
                                        input logic [IVL_W-1:0] ivl,
                                        input logic [IVL_W-1:0] rt,
                                        input bit typed, input logic [1:0] st);
    stim_row_t s;
    s.op = op;
    s.id = id;
    s.ivl = ivl;
    s.rt = rt;
    s.typed = typed;
    s.st = st;
    return s;
  endfunction

  // stimulus
  initial begin : stim
    int phase_start;
    int idle_set [4];
    int stall_set [4];
    idle_set = '{0, 56, 0, 21};
    stall_set = '{0, 0, 56, 21};

    // directed opening: empty table, reserved codes, extremes, ties, removal
    head_rows.push_back(dir_row(CMD_SELECT, 8'hFF, IVL_MAX, IVL_MAX, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, IVL_MAX, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_REMOVE, 8'h00, 24'h0, 24'h0, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_UPDATE, 8'hFF, IVL_MAX, 24'h0, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_RSVD6, 8'hFF, IVL_MAX, IVL_MAX, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_RSVD7, 8'h00, 24'h0, 24'h0, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_ADD, 8'hFF, IVL_MAX, IVL_MAX, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_ADD, 8'h00, 24'h0, 24'h0, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_ADD, 8'hA5, 24'h0, 24'h5A5A5A, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_SELECT, 8'h00, 24'h0, 24'h0, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, 24'h0, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, IVL_MAX, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_SELECT, 8'h00, 24'h0, 24'h0, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_UPDATE, 8'h5A, 24'h5A5A5A, 24'h0, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, 24'h1, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_SELECT, 8'h00, 24'h0, 24'h0, 1'b0, ST_OK));
    head_rows.push_back(dir_row(CMD_REMOVE, 8'h00, 24'h0, 24'h0, 1'b1, ST_OK));
    head_rows.push_back(dir_row(CMD_REMOVE, 8'h00, 24'h0, 24'h0, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, 24'h123456, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_UPDATE, 8'h00, IVL_MAX, 24'h0, 1'b1, ST_EMPTY));
    head_rows.push_back(dir_row(CMD_SELECT, 8'h00, 24'h0, 24'h0, 1'b0, ST_OK));

    // closing: stop, then everything reports stopped
    stop_rows.push_back(dir_row(CMD_STOP, 8'h00, 24'h0, 24'h0, 1'b1, ST_STOPPED));
    stop_rows.push_back(dir_row(CMD_ADD, 8'h11, 24'h10, 24'h0, 1'b1, ST_STOPPED));
    stop_rows.push_back(dir_row(CMD_SELECT, 8'h00, 24'h0, 24'h0, 1'b1, ST_STOPPED));
    stop_rows.push_back(dir_row(CMD_COMPLETE, 8'h00, 24'h0, IVL_MAX, 1'b1, ST_STOPPED));
    stop_rows.push_back(dir_row(CMD_STOP, 8'h00, 24'h0, 24'h0, 1'b1, ST_STOPPED));
    stop_rows.push_back(dir_row(CMD_RSVD7, 8'hFF, IVL_MAX, IVL_MAX, 1'b1, ST_STOPPED));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (head_rows[k]) begin
      send_request(head_rows[k].op, head_rows[k].id, head_rows[k].ivl, head_rows[k].rt,
                   head_rows[k].typed, head_rows[k].st);
    end

    // random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      phase_start = sent;
      if (p % 2 == 1) begin
        // long run of completes at maximum run time drives entries to the floor
        repeat (135) send_request(CMD_COMPLETE, JOB_W'($urandom), IVL_W'($urandom), IVL_MAX,
                                  1'b0, ST_OK);
      end
      while (sent - phase_start < ITEMS_PER_PHASE) run_sequence();
    end

    foreach (stop_rows[k]) begin
      send_request(stop_rows[k].op, stop_rows[k].id, stop_rows[k].ivl, stop_rows[k].rt,
                   stop_rows[k].typed, stop_rows[k].st);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d charges clamped at the floor",
             sent, checked, sat_events);
    $display("status seen: ok %0d, empty or no current %0d, full %0d, stopped %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pdjs_pkg.sv
rtl/core/pdjs_ram.sv
rtl/core/periodic_deadline_job_scheduler_top.sv
bench/tb_periodic_deadline_job_scheduler_top.sv
